// ===== rtl/frs_pkg.sv =====
// Package for the factory reset sequencer: state, opcode and command codes,
// configuration and item types shared by the rtl modules and the checker.
// No dependencies.
package frs_pkg;

    // Sequencer state codes as they appear on fsm_state
    localparam logic [3:0] RS_OFF      = 4'd0;
    localparam logic [3:0] RS_DRAIN    = 4'd1;
    localparam logic [3:0] RS_CONFIRM  = 4'd2;
    localparam logic [3:0] RS_MARK     = 4'd3;
    localparam logic [3:0] RS_PREPARE  = 4'd4;
    localparam logic [3:0] RS_CAL      = 4'd5;
    localparam logic [3:0] RS_BONDS    = 4'd6;
    localparam logic [3:0] RS_STORAGE  = 4'd7;
    localparam logic [3:0] RS_DEFAULTS = 4'd8;
    localparam logic [3:0] RS_COMMIT   = 4'd9;
    localparam logic [3:0] RS_FLASH    = 4'd10;
    localparam logic [3:0] RS_CHASE    = 4'd11;
    localparam logic [3:0] RS_PAIR     = 4'd12;
    localparam logic [3:0] RS_ERROR    = 4'd13;

    // Event opcodes
    localparam logic [2:0] OP_POLL    = 3'd0;
    localparam logic [2:0] OP_BUTTON  = 3'd1;
    localparam logic [2:0] OP_REQUEST = 3'd2;
    localparam logic [2:0] OP_BOOT    = 3'd3;
    localparam logic [2:0] OP_FAULT   = 3'd4;

    // Button actions
    localparam logic [1:0] BTN_OTHER    = 2'd0;
    localparam logic [1:0] BTN_SHUTDOWN = 2'd1;
    localparam logic [1:0] BTN_DOUBLE   = 2'd2;

    // Persisted marker values
    localparam logic [1:0] MRK_NONE     = 2'd0;
    localparam logic [1:0] MRK_PROGRESS = 2'd1;
    localparam logic [1:0] MRK_DONE     = 2'd2;

    // Shutdown command codes
    localparam logic [1:0] SHUT_NONE    = 2'd0;
    localparam logic [1:0] SHUT_REQUEST = 2'd1;
    localparam logic [1:0] SHUT_RESUME  = 2'd2;

    // Persist command codes
    localparam logic [1:0] PST_NONE     = 2'd0;
    localparam logic [1:0] PST_PROGRESS = 2'd1;
    localparam logic [1:0] PST_DONE     = 2'd2;

    // Step status: negative is failed, zero busy, one done
    localparam logic signed [1:0] STS_DONE = 2'sd1;

    // Configuration register indexes
    localparam logic [2:0] CFG_CONFIRM_TIMEOUT = 3'd0;
    localparam logic [2:0] CFG_PREPARE_TIMEOUT = 3'd1;
    localparam logic [2:0] CFG_LED_PHASE       = 3'd2;
    localparam logic [2:0] CFG_RETRY_DELAY     = 3'd3;
    localparam logic [2:0] CFG_MAX_RETRIES     = 3'd4;
    localparam logic [2:0] CFG_HOLD_CANCEL     = 3'd5;

    localparam logic [31:0] CONFIRM_TIMEOUT_RST = 32'd15000;
    localparam logic [31:0] PREPARE_TIMEOUT_RST = 32'd30000;
    localparam logic [31:0] LED_PHASE_RST       = 32'd1200;
    localparam logic [31:0] RETRY_DELAY_RST     = 32'd1000;
    localparam logic [1:0]  MAX_RETRIES_RST     = 2'd3;
    localparam logic [15:0] HOLD_CANCEL_RST     = 16'd1500;

    localparam int IN_TDATA_W  = 64;
    localparam int IN_FIELDS_W = 61;
    localparam int OUT_TDATA_W = 56;

    typedef struct packed {
        logic [31:0] confirm_timeout_ms;
        logic [31:0] prepare_timeout_ms;
        logic [31:0] led_phase_ms;
        logic [31:0] retry_delay_ms;
        logic [1:0]  max_retries;
        logic [15:0] hold_cancel_ms;
    } cfg_t;

    // Input item; last member sits in the lowest bits
    typedef struct packed {
        logic [1:0]        boot_marker;
        logic              action_ok;
        logic signed [1:0] storage_status;
        logic signed [1:0] prepare_status;
        logic              power_safe;
        logic              button_down;
        logic              link_quiet;
        logic [15:0]       hold_ms;
        logic              button_released;
        logic [1:0]        button_action;
        logic [31:0]       now_ms;
    } item_t;

    // Result item; last member sits in the lowest bits
    typedef struct packed {
        logic        confirming;
        logic        executing;
        logic        first_pair_required;
        logic [1:0]  retry_count;
        logic [3:0]  failed_step;
        logic [1:0]  persist_cmd;
        logic        cancel_cmd;
        logic [1:0]  shutdown_cmd;
        logic        lock_input;
        logic [31:0] elapsed_ms;
        logic [3:0]  fsm_state;
    } result_t;

endpackage

// ===== rtl/frs_cfg.sv =====
// Configuration register file for the factory reset sequencer.
// Depends on frs_pkg.
module frs_cfg
    import frs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output cfg_t        cfg
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.confirm_timeout_ms <= CONFIRM_TIMEOUT_RST;
            cfg_reg.prepare_timeout_ms <= PREPARE_TIMEOUT_RST;
            cfg_reg.led_phase_ms       <= LED_PHASE_RST;
            cfg_reg.retry_delay_ms     <= RETRY_DELAY_RST;
            cfg_reg.max_retries        <= MAX_RETRIES_RST;
            cfg_reg.hold_cancel_ms     <= HOLD_CANCEL_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_CONFIRM_TIMEOUT: cfg_reg.confirm_timeout_ms <= cfg_data;
                CFG_PREPARE_TIMEOUT: cfg_reg.prepare_timeout_ms <= cfg_data;
                CFG_LED_PHASE:       cfg_reg.led_phase_ms       <= cfg_data;
                CFG_RETRY_DELAY:     cfg_reg.retry_delay_ms     <= cfg_data;
                CFG_MAX_RETRIES:     cfg_reg.max_retries        <= cfg_data[1:0];
                CFG_HOLD_CANCEL:     cfg_reg.hold_cancel_ms     <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

endmodule

// ===== rtl/frs_step.sv =====
// Sequencer state and the single-pass step logic; writes the result register.
// Depends on frs_pkg.
module frs_step
    import frs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    advance,
    input  logic [2:0] opcode,
    input  item_t   item,
    output result_t result
);

    typedef enum logic [3:0] {
        OFF      = RS_OFF,
        DRAIN    = RS_DRAIN,
        CONFIRM  = RS_CONFIRM,
        MARK     = RS_MARK,
        PREPARE  = RS_PREPARE,
        CAL      = RS_CAL,
        BONDS    = RS_BONDS,
        STORAGE  = RS_STORAGE,
        DEFAULTS = RS_DEFAULTS,
        COMMIT   = RS_COMMIT,
        FLASH    = RS_FLASH,
        CHASE    = RS_CHASE,
        PAIR     = RS_PAIR,
        ERROR    = RS_ERROR
    } state_t;

    state_t      state_reg, state_next;
    logic [31:0] entry_reg, entry_next;
    logic [31:0] last_reg, last_next;
    logic [1:0]  marker_reg, marker_next;
    logic        resume_reg, resume_next;
    logic [3:0]  origin_reg, origin_next;
    logic [1:0]  retries_reg, retries_next;
    result_t     res_reg, res_next;

    logic [31:0] el;
    logic        go;
    state_t      target;
    logic        lock;
    logic [1:0]  shut;
    logic        cancel;
    logic [1:0]  persist;
    logic        prep_fail, prep_done, stor_fail, stor_done;
    logic        psafe, ok;

    assign result = res_reg;

    always_comb
    begin
        state_next   = state_reg;
        entry_next   = entry_reg;
        last_next    = last_reg;
        marker_next  = marker_reg;
        resume_next  = resume_reg;
        origin_next  = origin_reg;
        retries_next = retries_reg;
        go      = 1'b0;
        target  = state_reg;
        lock    = 1'b0;
        shut    = SHUT_NONE;
        cancel  = 1'b0;
        persist = PST_NONE;
        psafe   = item.power_safe;
        ok      = item.action_ok;
        el      = item.now_ms - entry_reg;
        prep_fail = item.prepare_status[1];
        prep_done = item.prepare_status == STS_DONE;
        stor_fail = item.storage_status[1];
        stor_done = item.storage_status == STS_DONE;

        case (opcode)
            OP_POLL:
            begin
                last_next = item.now_ms;
                // flash-writing steps hold still while the supply is low
                if (state_reg != OFF && !((state_reg inside {[CAL:COMMIT]}) && !psafe))
                begin
                    case (state_reg)
                        DRAIN:
                        begin
                            if (item.link_quiet)
                            begin
                                if (resume_reg)
                                begin
                                    go = 1'b1;
                                    target = PREPARE;
                                end
                                else if (!item.button_down)
                                begin
                                    lock = 1'b1;
                                    go = 1'b1;
                                    target = CONFIRM;
                                end
                            end
                        end
                        CONFIRM:
                        begin
                            if (el >= cfg.confirm_timeout_ms)
                            begin
                                go = 1'b1;
                                target = OFF;
                                cancel = 1'b1;
                            end
                        end
                        MARK:
                        begin
                            go = 1'b1;
                            if (!psafe || !ok)
                            begin
                                target = ERROR;
                            end
                            else
                            begin
                                marker_next = MRK_PROGRESS;
                                persist = PST_PROGRESS;
                                target = PREPARE;
                            end
                        end
                        PREPARE:
                        begin
                            if (psafe)
                            begin
                                if (prep_fail || el >= cfg.prepare_timeout_ms)
                                begin
                                    go = 1'b1;
                                    target = ERROR;
                                end
                                else if (prep_done)
                                begin
                                    go = 1'b1;
                                    target = CAL;
                                end
                            end
                        end
                        CAL:
                        begin
                            go = 1'b1;
                            target = ok ? BONDS : ERROR;
                        end
                        BONDS:
                        begin
                            go = 1'b1;
                            target = ok ? STORAGE : ERROR;
                        end
                        STORAGE:
                        begin
                            if (stor_fail)
                            begin
                                go = 1'b1;
                                target = ERROR;
                            end
                            else if (stor_done)
                            begin
                                go = 1'b1;
                                target = DEFAULTS;
                            end
                        end
                        DEFAULTS:
                        begin
                            go = 1'b1;
                            target = ok ? COMMIT : ERROR;
                        end
                        COMMIT:
                        begin
                            go = 1'b1;
                            if (ok)
                            begin
                                marker_next = MRK_DONE;
                                persist = PST_DONE;
                                target = FLASH;
                            end
                            else
                            begin
                                target = ERROR;
                            end
                        end
                        FLASH:
                        begin
                            if (el >= cfg.led_phase_ms)
                            begin
                                go = 1'b1;
                                target = CHASE;
                            end
                        end
                        CHASE:
                        begin
                            if (el >= cfg.led_phase_ms)
                            begin
                                go = 1'b1;
                                target = PAIR;
                            end
                        end
                        PAIR:
                        begin
                            if (ok)
                            begin
                                go = 1'b1;
                                target = OFF;
                            end
                        end
                        ERROR:
                        begin
                            // prepare and storage failures are never retried
                            if (el >= cfg.retry_delay_ms && retries_reg < cfg.max_retries &&
                                psafe && origin_reg != RS_STORAGE &&
                                origin_reg != RS_PREPARE)
                            begin
                                retries_next = retries_reg + 2'd1;
                                go = 1'b1;
                                target = state_t'(origin_reg);
                            end
                        end
                        default: ;
                    endcase
                end
            end
            OP_BUTTON:
            begin
                last_next = item.now_ms;
                if (state_reg == CONFIRM)
                begin
                    if (el >= cfg.confirm_timeout_ms || item.button_action == BTN_SHUTDOWN ||
                        item.hold_ms >= cfg.hold_cancel_ms)
                    begin
                        go = 1'b1;
                        target = OFF;
                        cancel = 1'b1;
                    end
                    else if (item.button_released && item.button_action == BTN_DOUBLE)
                    begin
                        go = 1'b1;
                        target = MARK;
                        lock = 1'b1;
                    end
                end
            end
            OP_REQUEST:
            begin
                if (state_reg == OFF)
                begin
                    resume_next = 1'b0;
                    retries_next = 2'd0;
                    go = 1'b1;
                    target = DRAIN;
                    shut = SHUT_REQUEST;
                    lock = 1'b1;
                end
            end
            OP_BOOT:
            begin
                marker_next = item.boot_marker;
                if (item.boot_marker == MRK_PROGRESS)
                begin
                    resume_next = 1'b1;
                    go = 1'b1;
                    target = DRAIN;
                    lock = 1'b1;
                    shut = SHUT_RESUME;
                end
            end
            OP_FAULT:
            begin
                if (!resume_reg && (state_reg == DRAIN || state_reg == CONFIRM))
                begin
                    go = 1'b1;
                    target = OFF;
                end
            end
            default: ;
        endcase

        if (go)
        begin
            if (target == ERROR)
            begin
                origin_next = state_reg;
            end
            state_next = target;
            entry_next = last_next;
        end

        res_next.fsm_state           = state_next;
        res_next.elapsed_ms          = last_next - entry_next;
        res_next.lock_input          = lock;
        res_next.shutdown_cmd        = shut;
        res_next.cancel_cmd          = cancel;
        res_next.persist_cmd         = persist;
        res_next.failed_step         = origin_next;
        res_next.retry_count         = retries_next;
        res_next.first_pair_required = marker_next != MRK_NONE;
        res_next.executing           = state_next >= MARK;
        res_next.confirming          = state_next == CONFIRM;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= OFF;
            entry_reg   <= '0;
            last_reg    <= '0;
            marker_reg  <= MRK_NONE;
            resume_reg  <= 1'b0;
            origin_reg  <= RS_OFF;
            retries_reg <= 2'd0;
        end
        else if (advance)
        begin
            state_reg   <= state_next;
            entry_reg   <= entry_next;
            last_reg    <= last_next;
            marker_reg  <= marker_next;
            resume_reg  <= resume_next;
            origin_reg  <= origin_next;
            retries_reg <= retries_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

endmodule

// ===== rtl/factory_reset_sequencer.sv =====
// Top level of the factory reset sequencer: input register, handshake control
// and the result register stage. Depends on frs_pkg, frs_cfg and frs_step.

// The sequencer takes one event per clock while the output side is ready and
// returns exactly one result per event: the event lands in an input register,
// then one pass through the step logic updates the sequencer state and fills
// the result register. Throughput is one event per cycle while m_tready holds,
// set by that single pass (32-bit elapsed-time subtract and timeout compares).
// An empty input register accepts a new event while a finished result waits on
// the output. Configuration writes are taken in any cycle and should
// only be issued while no event is in flight.
module factory_reset_sequencer
    import frs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // slave stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // now_ms[31:0], button_action[33:32], button_released[34], hold_ms[50:35],
    // link_quiet[51], button_down[52], power_safe[53], prepare_status[55:54],
    // storage_status[57:56], action_ok[58], boot_marker[60:59], zero fill
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // opcode[2:0]
    input  logic [2:0]             s_tuser,
    // master stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // fsm_state[3:0], elapsed_ms[35:4], lock_input[36], shutdown_cmd[38:37],
    // cancel_cmd[39], persist_cmd[41:40], failed_step[45:42], retry_count[47:46],
    // first_pair_required[48], executing[49], confirming[50], zero fill
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // configuration write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [2:0]             cfg_index,
    input  logic [31:0]            cfg_data
);

    cfg_t       cfg;
    item_t      item_reg;
    logic [2:0] op_reg;
    logic       in_valid_reg;
    logic       out_valid_reg;
    logic       advance;
    result_t    result;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - $bits(result_t)){1'b0}}, result};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg <= item_t'(s_tdata[IN_FIELDS_W-1:0]);
            op_reg   <= s_tuser;
        end
    end

    frs_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    frs_step u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .advance (advance),
        .opcode  (op_reg),
        .item    (item_reg),
        .result  (result)
    );

endmodule

// ===== rtl/frs_checker.sv =====
// Port-level checker for the factory reset sequencer, bound to the top level.
// Depends on frs_pkg and factory_reset_sequencer.
module frs_port_props
    import frs_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    logic [3:0] st;
    logic       lock;
    logic [1:0] shut;
    logic       cancel;
    logic [1:0] persist;

    assign st      = m_tdata[3:0];
    assign lock    = m_tdata[36];
    assign shut    = m_tdata[38:37];
    assign cancel  = m_tdata[39];
    assign persist = m_tdata[41:40];

    // A stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Status flags agree with the reported state
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[50] == (st == RS_CONFIRM)) && (m_tdata[49] == (st >= RS_MARK)))
        else $error("status flags disagree with state");

    // A cancel always lands in off
    a_cancel: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && cancel |-> st == RS_OFF)
        else $error("cancel outside off");

    // Writing the done marker enters the LED flash and sets first pairing
    a_persist: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && persist == PST_DONE |-> st == RS_FLASH && m_tdata[48])
        else $error("done marker without flash");

    // Shutdown and input lock pulses only come with entry to drain, confirm or mark
    a_lock: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (lock || shut != SHUT_NONE) |->
            st == RS_DRAIN || st == RS_CONFIRM || st == RS_MARK)
        else $error("lock or shutdown in wrong state");

endmodule

bind factory_reset_sequencer frs_port_props u_frs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/frs_checker.sv =====
// Checker for the factory reset sequencer: follows every stream and configuration
// transfer, predicts each status report and compares it with the one the block sends.
// Depends on frs_pkg.
module frs_checker
    import frs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic [2:0]             s_tuser,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [2:0]             cfg_index,
    input  logic [31:0]            cfg_data,
    output int                     mismatches,
    output int                     outstanding
);

    cfg_t        cfg;
    logic [3:0]  seq_state;
    logic [31:0] entry_ms;
    logic [31:0] last_ms;
    logic [1:0]  marker;
    logic        resuming;
    logic [3:0]  err_origin;
    logic [1:0]  retries;

    result_t expected_reports[$];

    function automatic void move_to(input logic [3:0] nxt);
        if (nxt == RS_ERROR)
            err_origin = seq_state;
        seq_state = nxt;
        entry_ms  = last_ms;
    endfunction

    function automatic result_t predict_status(input logic [2:0] op, input item_t ev);
        result_t     r;
        logic [31:0] el;
        logic        flash_step;
        r = '0;
        case (op)
            OP_POLL:
            begin
                last_ms = ev.now_ms;
                el = ev.now_ms - entry_ms;
                flash_step = (seq_state >= RS_CAL) && (seq_state <= RS_COMMIT);
                // flash-writing steps stall on a poll without safe supply
                if (seq_state != RS_OFF && !(flash_step && !ev.power_safe))
                begin
                    case (seq_state)
                        RS_DRAIN:
                            if (ev.link_quiet)
                            begin
                                if (resuming)
                                    move_to(RS_PREPARE);
                                else if (!ev.button_down)
                                begin
                                    r.lock_input = 1'b1;
                                    move_to(RS_CONFIRM);
                                end
                            end
                        RS_CONFIRM:
                            if (el >= cfg.confirm_timeout_ms)
                            begin
                                move_to(RS_OFF);
                                r.cancel_cmd = 1'b1;
                            end
                        RS_MARK:
                            if (!ev.power_safe || !ev.action_ok)
                                move_to(RS_ERROR);
                            else
                            begin
                                marker = MRK_PROGRESS;
                                r.persist_cmd = PST_PROGRESS;
                                move_to(RS_PREPARE);
                            end
                        RS_PREPARE:
                            if (ev.power_safe)
                            begin
                                if (ev.prepare_status[1] || el >= cfg.prepare_timeout_ms)
                                    move_to(RS_ERROR);
                                else if (ev.prepare_status == STS_DONE)
                                    move_to(RS_CAL);
                            end
                        RS_CAL:
                            move_to(ev.action_ok ? RS_BONDS : RS_ERROR);
                        RS_BONDS:
                            move_to(ev.action_ok ? RS_STORAGE : RS_ERROR);
                        RS_STORAGE:
                            if (ev.storage_status[1])
                                move_to(RS_ERROR);
                            else if (ev.storage_status == STS_DONE)
                                move_to(RS_DEFAULTS);
                        RS_DEFAULTS:
                            move_to(ev.action_ok ? RS_COMMIT : RS_ERROR);
                        RS_COMMIT:
                            if (ev.action_ok)
                            begin
                                marker = MRK_DONE;
                                r.persist_cmd = PST_DONE;
                                move_to(RS_FLASH);
                            end
                            else
                                move_to(RS_ERROR);
                        RS_FLASH:
                            if (el >= cfg.led_phase_ms)
                                move_to(RS_CHASE);
                        RS_CHASE:
                            if (el >= cfg.led_phase_ms)
                                move_to(RS_PAIR);
                        RS_PAIR:
                            if (ev.action_ok)
                                move_to(RS_OFF);
                        RS_ERROR:
                            // prepare and storage failures are never retried
                            if (el >= cfg.retry_delay_ms && retries < cfg.max_retries &&
                                ev.power_safe && err_origin != RS_STORAGE &&
                                err_origin != RS_PREPARE)
                            begin
                                retries = retries + 2'd1;
                                move_to(err_origin);
                            end
                        default:
                        begin
                        end
                    endcase
                end
            end
            OP_BUTTON:
            begin
                last_ms = ev.now_ms;
                if (seq_state == RS_CONFIRM)
                begin
                    if (ev.now_ms - entry_ms >= cfg.confirm_timeout_ms ||
                        ev.button_action == BTN_SHUTDOWN || ev.hold_ms >= cfg.hold_cancel_ms)
                    begin
                        move_to(RS_OFF);
                        r.cancel_cmd = 1'b1;
                    end
                    else if (ev.button_released && ev.button_action == BTN_DOUBLE)
                    begin
                        move_to(RS_MARK);
                        r.lock_input = 1'b1;
                    end
                end
            end
            OP_REQUEST:
                if (seq_state == RS_OFF)
                begin
                    resuming = 1'b0;
                    retries  = '0;
                    move_to(RS_DRAIN);
                    r.shutdown_cmd = SHUT_REQUEST;
                    r.lock_input   = 1'b1;
                end
            OP_BOOT:
            begin
                marker = ev.boot_marker;
                // a resumed reset keeps its retry count
                if (ev.boot_marker == MRK_PROGRESS)
                begin
                    resuming = 1'b1;
                    move_to(RS_DRAIN);
                    r.lock_input   = 1'b1;
                    r.shutdown_cmd = SHUT_RESUME;
                end
            end
            OP_FAULT:
                if (!resuming && (seq_state == RS_DRAIN || seq_state == RS_CONFIRM))
                    move_to(RS_OFF);
            default:
            begin
            end
        endcase
        r.fsm_state           = seq_state;
        r.elapsed_ms          = last_ms - entry_ms;
        r.failed_step         = err_origin;
        r.retry_count         = retries;
        r.first_pair_required = (marker != MRK_NONE);
        r.executing           = (seq_state >= RS_MARK);
        r.confirming          = (seq_state == RS_CONFIRM);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic compare_report(input result_t want, input result_t got);
        check_field("fsm_state", 32'(want.fsm_state), 32'(got.fsm_state));
        check_field("elapsed_ms", want.elapsed_ms, got.elapsed_ms);
        check_field("lock_input", 32'(want.lock_input), 32'(got.lock_input));
        check_field("shutdown_cmd", 32'(want.shutdown_cmd), 32'(got.shutdown_cmd));
        check_field("cancel_cmd", 32'(want.cancel_cmd), 32'(got.cancel_cmd));
        check_field("persist_cmd", 32'(want.persist_cmd), 32'(got.persist_cmd));
        check_field("failed_step", 32'(want.failed_step), 32'(got.failed_step));
        check_field("retry_count", 32'(want.retry_count), 32'(got.retry_count));
        check_field("first_pair_required", 32'(want.first_pair_required),
                    32'(got.first_pair_required));
        check_field("executing", 32'(want.executing), 32'(got.executing));
        check_field("confirming", 32'(want.confirming), 32'(got.confirming));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg.confirm_timeout_ms = CONFIRM_TIMEOUT_RST;
            cfg.prepare_timeout_ms = PREPARE_TIMEOUT_RST;
            cfg.led_phase_ms       = LED_PHASE_RST;
            cfg.retry_delay_ms     = RETRY_DELAY_RST;
            cfg.max_retries        = MAX_RETRIES_RST;
            cfg.hold_cancel_ms     = HOLD_CANCEL_RST;
            seq_state  = RS_OFF;
            entry_ms   = '0;
            last_ms    = '0;
            marker     = MRK_NONE;
            resuming   = 1'b0;
            err_origin = RS_OFF;
            retries    = '0;
            mismatches = 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_CONFIRM_TIMEOUT: cfg.confirm_timeout_ms = cfg_data;
                    CFG_PREPARE_TIMEOUT: cfg.prepare_timeout_ms = cfg_data;
                    CFG_LED_PHASE:       cfg.led_phase_ms       = cfg_data;
                    CFG_RETRY_DELAY:     cfg.retry_delay_ms     = cfg_data;
                    CFG_MAX_RETRIES:     cfg.max_retries        = cfg_data[1:0];
                    CFG_HOLD_CANCEL:     cfg.hold_cancel_ms     = cfg_data[15:0];
                    default:
                    begin
                    end
                endcase
            end
            // compare before pushing, so an early report cannot match its own event
            if (m_tvalid === 1'b1 && m_tready)
            begin
                if (expected_reports.size() == 0)
                begin
                    $display("%0t: report with nothing expected: got %0h", $time, m_tdata);
                    mismatches++;
                end
                else
                    compare_report(expected_reports.pop_front(),
                                   m_tdata[$bits(result_t)-1:0]);
            end
            if (s_tvalid && s_tready === 1'b1)
                expected_reports.push_back(predict_status(s_tuser,
                                                          s_tdata[IN_FIELDS_W-1:0]));
            outstanding <= expected_reports.size();
        end
    end

endmodule

// ===== tb/tb_factory_reset_sequencer.sv =====
// Testbench top for factory_reset_sequencer: clock, reset, event and configuration
// stimulus with random idling, and the verdict. Depends on frs_pkg, frs_checker
// and the rtl.
module tb_factory_reset_sequencer;
    import frs_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_ITEMS  = 350;

    localparam logic [2:0]        OP_SPARE_LO = 3'd5;
    localparam logic [2:0]        OP_SPARE_HI = 3'd7;
    localparam logic signed [1:0] STS_BUSY    = 2'sd0;
    localparam logic signed [1:0] STS_FAIL_2  = -2'sd2;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic [2:0]             s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [2:0]             cfg_index = '0;
    logic [31:0]            cfg_data  = '0;
    logic                   calm      = 1'b0;

    int          mismatches;
    int          outstanding;
    int          items_sent = 0;
    logic [31:0] now_q      = '0;

    factory_reset_sequencer i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    frs_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .outstanding(outstanding)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
        m_tready <= calm || ($urandom_range(0, 99) >= 30);

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("** factory_reset_sequencer: FAILED **");
        $finish;
    end

    function automatic cfg_t make_cfg(input logic [31:0] confirm_to, input logic [31:0] prep_to,
                                      input logic [31:0] led, input logic [31:0] retry_dly,
                                      input logic [1:0] max_rt, input logic [15:0] hold);
        cfg_t c;
        c.confirm_timeout_ms = confirm_to;
        c.prepare_timeout_ms = prep_to;
        c.led_phase_ms       = led;
        c.retry_delay_ms     = retry_dly;
        c.max_retries        = max_rt;
        c.hold_cancel_ms     = hold;
        return c;
    endfunction

    // An event that moves a healthy reset forward; the clock advances a little,
    // now and then a lot
    function automatic item_t nominal_event();
        item_t it;
        int    pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            now_q = now_q + $urandom_range(0, 60);
        else if (pick < 96)
            now_q = now_q + $urandom_range(0, 1500);
        else
            now_q = $urandom;
        it.now_ms          = now_q;
        it.button_action   = BTN_DOUBLE;
        it.button_released = 1'b1;
        it.hold_ms         = 16'($urandom_range(0, 30));
        it.link_quiet      = 1'b1;
        it.button_down     = 1'b0;
        it.power_safe      = 1'b1;
        it.prepare_status  = ($urandom_range(0, 3) == 0) ? STS_BUSY : STS_DONE;
        it.storage_status  = ($urandom_range(0, 3) == 0) ? STS_BUSY : STS_DONE;
        it.action_ok       = 1'b1;
        it.boot_marker     = 2'($urandom);
        return it;
    endfunction

    function automatic item_t perturb(input item_t it);
        item_t p;
        p = it;
        case ($urandom_range(0, 8))
            0: p.action_ok       = 1'b0;
            1: p.power_safe      = 1'b0;
            2: p.prepare_status  = 2'($urandom);
            3: p.storage_status  = 2'($urandom);
            4: p.link_quiet      = 1'b0;
            5: p.button_down     = 1'b1;
            6: p.hold_ms         = 16'($urandom);
            7: p.button_action   = 2'($urandom);
            default: p.button_released = 1'b0;
        endcase
        return p;
    endfunction

    // valid stays high across back-to-back events; it drops only for idle cycles
    task automatic send_event(input logic [2:0] op, input item_t it);
        if (!calm)
        begin
            while ($urandom_range(0, 99) < 30)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(IN_TDATA_W-IN_FIELDS_W){1'b0}}, it};
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        items_sent++;
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_config(input cfg_t c);
        logic [2:0]  idx[6];
        logic [31:0] val[6];
        idx[0] = CFG_CONFIRM_TIMEOUT;  val[0] = c.confirm_timeout_ms;
        idx[1] = CFG_PREPARE_TIMEOUT;  val[1] = c.prepare_timeout_ms;
        idx[2] = CFG_LED_PHASE;        val[2] = c.led_phase_ms;
        idx[3] = CFG_RETRY_DELAY;      val[3] = c.retry_delay_ms;
        // narrow registers get junk in the unused upper bits
        idx[4] = CFG_MAX_RETRIES;      val[4] = {30'($urandom), c.max_retries};
        idx[5] = CFG_HOLD_CANCEL;      val[5] = {16'($urandom), c.hold_cancel_ms};
        for (int i = 0; i < 6; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do
                @(posedge clk);
            while (cfg_ready !== 1'b1);
        end
        cfg_valid <= 1'b0;
    endtask

    // One reset attempt: start, drain, confirm, then a run of polls with faults mixed in
    task automatic run_flow();
        item_t it;
        int    pick;
        it = nominal_event();
        if ($urandom_range(0, 3) == 0)
        begin
            it.boot_marker = MRK_PROGRESS;
            send_event(OP_BOOT, it);
        end
        else
            send_event(OP_REQUEST, it);
        repeat ($urandom_range(0, 2))
        begin
            it = nominal_event();
            it.link_quiet  = 1'($urandom);
            it.button_down = 1'($urandom);
            send_event(OP_POLL, it);
        end
        send_event(OP_POLL, nominal_event());
        it = nominal_event();
        if ($urandom_range(0, 4) == 0)
            it = perturb(it);
        send_event(OP_BUTTON, it);
        repeat ($urandom_range(14, 30))
        begin
            it = nominal_event();
            pick = $urandom_range(0, 99);
            if (pick < 12)
                it = perturb(it);
            if (pick >= 94)
                send_event(3'($urandom_range(1, 7)), it);
            else
                send_event(OP_POLL, it);
        end
    endtask

    task automatic noise_burst();
        logic [63:0] raw;
        repeat ($urandom_range(3, 12))
        begin
            raw = {$urandom, $urandom};
            send_event(3'($urandom), raw[IN_FIELDS_W-1:0]);
        end
    endtask

    task automatic run_phase(input cfg_t c, input logic no_idle);
        int goal;
        settle();
        write_config(c);
        calm <= no_idle;
        goal = items_sent + PHASE_ITEMS;
        while (items_sent < goal)
        begin
            if ($urandom_range(0, 9) == 0)
                noise_burst();
            else
                run_flow();
        end
    endtask

    initial
    begin
        item_t it;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, reset values of the registers in force
        send_event(OP_SPARE_LO, nominal_event());
        it = nominal_event();
        it.now_ms = '0;
        send_event(OP_POLL, it);
        send_event(OP_FAULT, nominal_event());
        now_q = '1;
        it = nominal_event();
        it.now_ms = '1;
        send_event(OP_POLL, it);
        send_event(OP_REQUEST, nominal_event());
        send_event(OP_REQUEST, nominal_event());        // ignored while active
        it = nominal_event();
        it.link_quiet = 1'b0;
        send_event(OP_POLL, it);
        it = nominal_event();
        it.button_down = 1'b1;
        send_event(OP_POLL, it);
        send_event(OP_POLL, nominal_event());           // into confirm
        it = nominal_event();
        it.button_action   = BTN_OTHER;
        it.button_released = 1'b0;
        it.hold_ms         = '0;
        send_event(OP_BUTTON, it);
        it = nominal_event();
        it.hold_ms = '1;                                // long hold cancels
        send_event(OP_BUTTON, it);
        send_event(OP_REQUEST, nominal_event());
        send_event(OP_POLL, nominal_event());
        send_event(OP_FAULT, nominal_event());          // fault cancel from confirm
        send_event(OP_REQUEST, nominal_event());
        send_event(OP_POLL, nominal_event());
        send_event(OP_BUTTON, nominal_event());         // double click, into mark
        it = nominal_event();
        it.power_safe = 1'b0;
        send_event(OP_POLL, it);
        it = nominal_event();
        it.boot_marker = MRK_DONE;
        send_event(OP_BOOT, it);
        it.boot_marker = MRK_NONE;
        send_event(OP_BOOT, it);
        it.boot_marker = MRK_PROGRESS;                  // resumed drain
        send_event(OP_BOOT, it);
        send_event(OP_FAULT, nominal_event());          // no effect on a resumed reset
        send_event(OP_POLL, nominal_event());
        it = nominal_event();
        it.prepare_status = STS_FAIL_2;
        send_event(OP_POLL, it);
        it = nominal_event();
        it.now_ms = now_q + 32'd50000;
        now_q = it.now_ms;
        send_event(OP_POLL, it);                        // failed prepare is not retried
        send_event(OP_SPARE_HI, nominal_event());

        run_phase(make_cfg(32'd400, 32'd300, 32'd200, 32'd100, 2'd1, 16'd50), 1'b0);
        run_phase(make_cfg('0, '0, '0, '0, '0, '0), 1'b0);
        run_phase(make_cfg('1, '1, '1, '1, 2'd3, '1), 1'b0);
        run_phase(make_cfg($urandom_range(500, 20000), $urandom_range(200, 40000),
                           $urandom_range(0, 3000), $urandom_range(0, 2000),
                           2'($urandom), 16'($urandom_range(40, 3000))), 1'b1);
        run_phase(make_cfg(CONFIRM_TIMEOUT_RST, PREPARE_TIMEOUT_RST, LED_PHASE_RST,
                           RETRY_DELAY_RST, 2'd2, HOLD_CANCEL_RST), 1'b0);

        settle();
        if (mismatches == 0)
            $display("** factory_reset_sequencer: PASSED **");
        else
            $display("** factory_reset_sequencer: FAILED **");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/frs_pkg.sv
rtl/frs_cfg.sv
rtl/frs_step.sv
rtl/factory_reset_sequencer.sv
rtl/frs_checker.sv
tb/frs_checker.sv
tb/tb_factory_reset_sequencer.sv
